// ===== design/moving_average_filter_unit_macros.svh =====
// assertion helpers shared by the filter modules
// every module that uses them has clk_i and rst_ni in scope
`ifndef MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH
`define MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define MAF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/maf_pkg.sv =====
package maf_pkg;

  // ring and sample geometry
  localparam int MaxSamples = 64;
  localparam int SampleBits = 16;
  localparam int StampW     = 32;
  localparam int WinSampW   = 7;

  localparam int PtrW = $clog2(MaxSamples);
  localparam int CntW = $clog2(MaxSamples + 1);
  localparam int SumW = SampleBits + PtrW;
  localparam int NumW = SumW + 1;
  localparam int DenW = CntW + 1;

  // front request queue
  localparam int FrontDepth = 2;
  localparam int FrontPtrW  = $clog2(FrontDepth);
  localparam int FrontCntW  = $clog2(FrontDepth + 1);

  // register port
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;
  localparam int RegIdxW  = ApbAddrW - 2;

  localparam logic [RegIdxW-1:0] RegMode       = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegWinSamples = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegWinMs      = RegIdxW'(2);

  localparam logic                ModeReset       = 1'b0;
  localparam logic [WinSampW-1:0] WinSamplesReset = WinSampW'(8);
  localparam logic [StampW-1:0]   WinMsReset      = StampW'(1000);

  typedef enum logic {
    FuncSample = 1'b0,
    FuncClear  = 1'b1
  } func_e;

  typedef struct packed {
    logic                         is_clear;
    logic signed [SampleBits-1:0] sample;
    logic [StampW-1:0]            stamp;
  } item_t;

  typedef struct packed {
    logic [StampW-1:0]            stamp;
    logic signed [SampleBits-1:0] sample;
  } entry_t;

  typedef struct packed {
    logic                mode;
    logic [WinSampW-1:0] win_samples;
    logic [StampW-1:0]   win_ms;
  } cfg_t;

endpackage

// ===== design/maf_front.sv =====
`include "moving_average_filter_unit_macros.svh"

module maf_front import maf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         func_i,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic [StampW-1:0]            timestamp_ms_i,
  output logic                         full_o,
  output logic                         item_valid_o,
  output item_t                        item_o,
  input  logic                         item_pop_i
);

  item_t                q_mem [FrontDepth];
  logic [FrontPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FrontCntW-1:0] fill_q, fill_d;
  logic                 accept;
  item_t                new_item;

  assign full_o       = (fill_q == FrontCntW'(FrontDepth));
  assign item_valid_o = (fill_q != '0);
  assign item_o       = q_mem[rd_ptr_q];
  assign accept       = push_i && !full_o;

  // classify the request
  always_comb begin
    new_item.is_clear = (func_i == FuncClear);
    new_item.sample   = sample_i;
    new_item.stamp    = timestamp_ms_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == FrontPtrW'(FrontDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_ptr_d = (rd_ptr_q == FrontPtrW'(FrontDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (accept && !item_pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!accept && item_pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= new_item;
    end
  end

  `MAF_ASSERT_IMP(a_pop_not_empty, item_pop_i, item_valid_o, "pop from empty front queue")
  `MAF_ASSERT_NXT(a_accept_visible, accept && !item_pop_i, item_valid_o, "accepted request lost")
  `MAF_ASSERT_NXT(a_head_holds, item_valid_o && !item_pop_i, $stable(item_o), "queue head changed")

endmodule

// ===== design/maf_div.sv =====
module maf_div import maf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int IterW = $clog2(NumW);

  logic             busy_q, busy_d, done_q, done_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic [NumW-1:0]  quo_q, quo_d;
  logic [DenW-1:0]  rem_q, rem_d, den_q, den_d;
  logic [DenW:0]    rem_sh, rem_sub;
  logic             ge;

  // one restoring step per cycle, msb first
  assign rem_sh  = {rem_q, quo_q[NumW-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = IterW'(NumW - 1);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NumW-2:0], ge};
      rem_d = ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      iter_d = iter_q - 1'b1;
      if (iter_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== design/maf_back.sv =====
`include "moving_average_filter_unit_macros.svh"

module maf_back import maf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         item_valid_i,
  input  item_t                        item_i,
  output logic                         item_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic signed [SampleBits-1:0] average_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRd    = 3'd1;
  localparam logic [2:0] StChk   = 3'd2;
  localparam logic [2:0] StWr    = 3'd3;
  localparam logic [2:0] StStart = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0]                   state_q, state_d;
  item_t                        item_q, item_d;
  logic [PtrW-1:0]              wp_q, wp_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic signed [SumW-1:0]       sum_q, sum_d;
  logic signed [SampleBits-1:0] avg_q, avg_d;
  logic                         out_valid_q, out_valid_d;

  entry_t store [MaxSamples];
  entry_t rd_q;
  logic   mem_we, mem_re;

  logic [CntW-1:0]       n_eff;
  logic [PtrW+1:0]       old_sum;
  logic [PtrW+1:0]       old_wrap;
  logic [PtrW-1:0]       old_idx;
  logic                  drop_cand;
  logic [StampW-1:0]     age;
  logic                  expired;
  logic                  ring_full;
  logic signed [SumW-1:0] sum_drop, sum_add;
  logic [SumW-1:0]       mag;
  logic [NumW-1:0]       num;
  logic [DenW-1:0]       den;
  logic                  div_start, div_busy, div_done;
  logic [NumW-1:0]       div_quot;
  logic [SampleBits-1:0] q_lo;
  logic [SampleBits-1:0] avg_calc;

  // effective sample window, clamped to one..ring size
  always_comb begin
    if (cfg_i.win_samples == '0) begin
      n_eff = CntW'(1);
    end else if (32'(cfg_i.win_samples) > 32'(MaxSamples)) begin
      n_eff = CntW'(MaxSamples);
    end else begin
      n_eff = CntW'(cfg_i.win_samples);
    end
  end

  // oldest slot of the ring
  assign old_sum  = (PtrW+2)'(wp_q) + (PtrW+2)'(MaxSamples) - (PtrW+2)'(cnt_q);
  assign old_wrap = old_sum - (PtrW+2)'(MaxSamples);
  assign old_idx  = (old_sum >= (PtrW+2)'(MaxSamples)) ? old_wrap[PtrW-1:0]
                                                       : old_sum[PtrW-1:0];

  assign drop_cand = (cnt_q != '0) && (cfg_i.mode || (cnt_q >= n_eff));
  assign age       = item_q.stamp - rd_q.stamp;
  assign expired   = (age >= cfg_i.win_ms);
  assign ring_full = (cnt_q == CntW'(MaxSamples));
  assign sum_drop  = sum_q - SumW'($signed(rd_q.sample));
  assign sum_add   = sum_q + SumW'($signed(item_q.sample));

  // rounding: (2*|sum| + n) / (2*n)
  assign mag = sum_q[SumW-1] ? (~sum_q + 1'b1) : sum_q;
  assign num = {mag, 1'b0} + NumW'(cnt_q);
  assign den = {cnt_q, 1'b0};

  assign q_lo     = div_quot[SampleBits-1:0];
  assign avg_calc = sum_q[SumW-1] ? (~q_lo + 1'b1) : q_lo;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q && !pop_i;
    item_pop_o  = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          if (item_i.is_clear) begin
            wp_d    = '0;
            cnt_d   = '0;
            sum_d   = '0;
            state_d = StOut;
          end else begin
            state_d = StRd;
          end
        end
      end
      StRd: begin
        if (drop_cand) begin
          mem_re  = 1'b1;
          state_d = StChk;
        end else begin
          state_d = StWr;
        end
      end
      StChk: begin
        if (!cfg_i.mode || expired) begin
          cnt_d   = cnt_q - 1'b1;
          sum_d   = sum_drop;
          state_d = StRd;
        end else if (ring_full) begin
          // full ring loses its oldest entry even if still in the window
          cnt_d   = cnt_q - 1'b1;
          sum_d   = sum_drop;
          state_d = StWr;
        end else begin
          state_d = StWr;
        end
      end
      StWr: begin
        mem_we  = 1'b1;
        wp_d    = (wp_q == PtrW'(MaxSamples - 1)) ? '0 : wp_q + 1'b1;
        cnt_d   = cnt_q + 1'b1;
        sum_d   = sum_add;
        state_d = StStart;
      end
      StStart: begin
        div_start = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || pop_i) begin
          avg_d       = item_q.is_clear ? '0 : $signed(avg_calc);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wp_q        <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    avg_q  <= avg_d;
  end

  // sample and timestamp ring
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[wp_q] <= '{stamp: item_q.stamp, sample: item_q.sample};
    end
    if (mem_re) begin
      rd_q <= store[old_idx];
    end
  end

  maf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign empty_o   = !out_valid_q;
  assign average_o = avg_q;

  `MAF_ASSERT_NXT(a_store_nonempty, state_q == StWr, cnt_q != '0, "count zero after store")
  `MAF_ASSERT_IMP(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")
  `MAF_ASSERT_NXT(a_result_held, out_valid_q && !pop_i, out_valid_q && $stable(avg_q),
                  "pending result overwritten")

endmodule

// ===== design/moving_average_filter_unit.sv =====
// Moving-average filter. Each sample request carries a signed 16-bit sample and a
// millisecond timestamp; the block stores both in a 64-entry ring, keeps an exact
// running sum and answers with the window average rounded to nearest, ties away from
// zero. In sample mode (mode = 0) the window is the last window_samples samples
// (0 acts as 1, above 64 acts as 64). In time mode (mode = 1) entries whose wrapped
// age (timestamp_ms - stamp) is at least window_ms are dropped oldest first, then a
// full ring drops its oldest entry. A clear request (func = 1) empties the ring and
// answers 0. Requests enter through a two-deep queue (push/full), results leave
// through a one-deep result register (empty/pop), so either side may stall on its
// own. A sample request passes from the head of the request queue to the result
// register by a walk of the ring: each entry dropped by the sample window or by
// expiry costs one read of the single-port ring plus a compare, and in time mode
// the walk also reads and compares the stored entry at which it stops when that
// entry has not expired (that same read and compare also drops it when the ring
// is full); the rounding divide is then a bit-serial restoring divider of 23 steps.
// A clear request goes straight to the result register. Registers (APB, 32-bit
// data): 0x0 mode, 0x4 window_samples, 0x8 window_ms; write them only while the
// block is idle. The ring needs no initialization after reset.
module moving_average_filter_unit import maf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ApbAddrW-1:0]          paddr,
  input  logic [ApbDataW-1:0]          pwdata,
  output logic [ApbDataW-1:0]          prdata,
  output logic                         pready,
  // request side
  input  logic                         push,
  output logic                         full,
  input  logic                         func_i,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic [StampW-1:0]            timestamp_ms_i,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic signed [SampleBits-1:0] average_o
);

  cfg_t                cfg_q, cfg_d;
  logic [RegIdxW-1:0]  reg_idx;
  logic                reg_wr;
  logic                item_valid;
  item_t               item;
  logic                item_pop;

  // register decode, always ready
  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (reg_wr) begin
      case (reg_idx)
        RegMode:       cfg_d.mode        = pwdata[0];
        RegWinSamples: cfg_d.win_samples = pwdata[WinSampW-1:0];
        RegWinMs:      cfg_d.win_ms      = pwdata[StampW-1:0];
        default:       cfg_d             = cfg_q;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      RegMode:       prdata = ApbDataW'(cfg_q.mode);
      RegWinSamples: prdata = ApbDataW'(cfg_q.win_samples);
      RegWinMs:      prdata = ApbDataW'(cfg_q.win_ms);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= ModeReset;
      cfg_q.win_samples <= WinSamplesReset;
      cfg_q.win_ms      <= WinMsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: request queue and classification
  maf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .func_i         (func_i),
    .sample_i       (sample_i),
    .timestamp_ms_i (timestamp_ms_i),
    .full_o         (full),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  // back: ring walk, running sum, rounding divide, result register
  maf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .average_o    (average_o)
  );

endmodule
